/* src/hs5_pkg.sv */
// Shared types and constants for the five-point heat stencil block.
package hs5_pkg;

    // Sample and arithmetic widths.
    localparam int SampleBits = 32;
    localparam int SumBits    = 34;
    localparam int BetaBits   = 19;
    localparam int AlphaBits  = 17;
    localparam int ProdBits   = 51;
    localparam int FracBits   = 16;
    localparam int TotalBits  = 36;

    // Configuration register widths and limits.
    localparam int CfgBits     = 11;
    localparam int CoeffBits   = 16;
    localparam int CfgIdxBits  = 2;
    localparam int CfgDataBits = 16;
    localparam int RowLimit    = 1024;

    // Result queue between the front and back parts.
    localparam int QDepth   = 4;
    localparam int QPtrBits = 2;
    localparam int QCntBits = 3;

    // Configuration register indexes.
    localparam logic [CfgIdxBits-1:0] CFG_GRID_COLS       = 2'd0;
    localparam logic [CfgIdxBits-1:0] CFG_GRID_ROWS       = 2'd1;
    localparam logic [CfgIdxBits-1:0] CFG_DIFFUSION_COEFF = 2'd2;

    // Saturation limits for a sample.
    localparam logic [SampleBits-1:0] SatMaxPos = {1'b0, {(SampleBits-1){1'b1}}};
    localparam logic [SampleBits-1:0] SatMinNeg = {1'b1, {(SampleBits-1){1'b0}}};

    // One in Q2.16, the base of beta = 1 - 4a.
    localparam logic [BetaBits-1:0] BetaOne = 19'h10000;

    // Configuration registers as seen by the datapath.
    typedef struct packed {
        logic [CfgBits-1:0]   grid_cols;
        logic [CfgBits-1:0]   grid_rows;
        logic [CoeffBits-1:0] diffusion_coeff;
    } t_cfg;

    // One classified stencil point handed from front to back.
    typedef struct packed {
        logic signed [SampleBits-1:0] centre;
        logic signed [SumBits-1:0]    sum;
        logic                         last;
    } t_item;

endpackage

/* src/hs5_front.sv */
// Front part: raster counters, line stores, west window and point classification.
module hs5_front #(
    parameter int MAX_COLS = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  hs5_pkg::t_cfg                       i_cfg,
    input  logic                                i_restart,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [hs5_pkg::SampleBits-1:0] i_sample,
    input  logic [hs5_pkg::QCntBits-1:0]        i_q_count,
    output logic                                o_push,
    output hs5_pkg::t_item                      o_item
);

    localparam int Depth    = MAX_COLS + 2;
    localparam int AddrBits = $clog2(Depth);
    localparam int RowBits  = hs5_pkg::CfgBits;
    localparam int SB       = hs5_pkg::SampleBits;
    localparam int CntBits  = hs5_pkg::QCntBits + 1;

    // Line stores: previous row and the row before it.
    logic [SB-1:0] mem_mid   [Depth];
    logic [SB-1:0] mem_north [Depth];

    logic [AddrBits-1:0] r_col, n_col;
    logic [RowBits-1:0]  r_row, n_row;
    logic                r_clr_busy;
    logic [AddrBits-1:0] r_clr_addr;

    logic signed [SB-1:0] r_rd_centre;
    logic signed [SB-1:0] r_rd_east;
    logic signed [SB-1:0] r_rd_north;
    logic signed [SB-1:0] r_west;

    logic                 r_f1_valid;
    logic signed [SB-1:0] r_f1_south;
    logic [AddrBits-1:0]  r_f1_col;
    logic                 r_f1_emit;
    logic                 r_f1_last;

    logic [AddrBits-1:0] w_cols;
    logic [AddrBits-1:0] w_col_end;
    logic [RowBits-1:0]  w_rows;
    logic [RowBits-1:0]  w_row_end;
    logic [AddrBits:0]   w_east_wide;
    logic [AddrBits-1:0] w_east_addr;
    logic                w_accept;
    logic                w_emit;
    logic                w_last;
    logic                w_we;
    logic [AddrBits-1:0] w_waddr;
    logic [SB-1:0]       w_wmid;
    logic [SB-1:0]       w_wnorth;

    // Clamp the configured grid size to the supported range.
    always_comb begin
        if (i_cfg.grid_cols == '0) begin
            w_cols = AddrBits'(1);
        end else if (int'(i_cfg.grid_cols) > MAX_COLS) begin
            w_cols = AddrBits'(MAX_COLS);
        end else begin
            w_cols = AddrBits'(i_cfg.grid_cols);
        end
        if (i_cfg.grid_rows == '0) begin
            w_rows = RowBits'(1);
        end else if (int'(i_cfg.grid_rows) > hs5_pkg::RowLimit) begin
            w_rows = RowBits'(hs5_pkg::RowLimit);
        end else begin
            w_rows = i_cfg.grid_rows;
        end
    end

    assign w_col_end = w_cols + AddrBits'(1);
    assign w_row_end = w_rows + RowBits'(1);

    // The east read only matters for interior columns, so the wrap at the top is harmless.
    assign w_east_wide = {1'b0, r_col} + (AddrBits+1)'(1);
    assign w_east_addr = w_east_wide[AddrBits-1:0];

    // Take a sample only when the queue can absorb it and the in-flight one.
    assign o_in_ready = !r_clr_busy &&
        ((CntBits'(i_q_count) + CntBits'(r_f1_valid)) < CntBits'(hs5_pkg::QDepth));
    assign w_accept = i_in_valid && o_in_ready;

    // A point is interior from the third row on, between the halo columns.
    assign w_emit = (r_row >= RowBits'(2)) && (r_col != '0) && (r_col <= w_cols);
    assign w_last = (r_row == w_row_end) && (r_col == w_cols);

    // Raster position of the next sample.
    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_restart) begin
            n_col = '0;
            n_row = '0;
        end else if (w_accept) begin
            if (r_col == w_col_end) begin
                n_col = '0;
                n_row = (r_row == w_row_end) ? '0 : r_row + RowBits'(1);
            end else begin
                n_col = r_col + AddrBits'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Clearing pass over both line stores after reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AddrBits'(Depth - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + AddrBits'(1);
        end
    end

    // Store write port: the clearing pass, then the sample in the cycle after its transfer.
    always_comb begin
        if (r_clr_busy) begin
            w_we     = 1'b1;
            w_waddr  = r_clr_addr;
            w_wmid   = '0;
            w_wnorth = '0;
        end else begin
            w_we     = r_f1_valid;
            w_waddr  = r_f1_col;
            w_wmid   = r_f1_south;
            w_wnorth = r_rd_centre;
        end
    end

    // Middle row store: centre and east reads for the accepted sample.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_mid[w_waddr] <= w_wmid;
        end
        if (w_accept) begin
            r_rd_centre <= mem_mid[r_col];
            r_rd_east   <= mem_mid[w_east_addr];
        end
    end

    // North row store.
    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem_north[w_waddr] <= w_wnorth;
        end
        if (w_accept) begin
            r_rd_north <= mem_north[r_col];
        end
    end

    // Second front stage: holds the sample while the store data arrives.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_f1_valid <= 1'b0;
            r_west     <= '0;
        end else begin
            r_f1_valid <= w_accept;
            if (r_f1_valid) begin
                r_west <= r_rd_centre;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_f1_south <= i_sample;
            r_f1_col   <= r_col;
            r_f1_emit  <= w_emit;
            r_f1_last  <= w_last;
        end
    end

    // Hand the centre and the exact neighbour sum to the back part.
    assign o_push        = r_f1_valid && r_f1_emit;
    assign o_item.centre = r_rd_centre;
    assign o_item.sum    = hs5_pkg::SumBits'(r_rd_north) + hs5_pkg::SumBits'(r_f1_south)
                         + hs5_pkg::SumBits'(r_west) + hs5_pkg::SumBits'(r_rd_east);
    assign o_item.last   = r_f1_last;

endmodule

/* src/hs5_queue.sv */
// Short queue of classified points between the front and back parts.
module hs5_queue (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_push,
    input  hs5_pkg::t_item                i_item,
    input  logic                          i_pop,
    output logic                          o_valid,
    output hs5_pkg::t_item                o_item,
    output logic [hs5_pkg::QCntBits-1:0]  o_count
);

    hs5_pkg::t_item                r_slot [hs5_pkg::QDepth];
    logic [hs5_pkg::QPtrBits-1:0]  r_wr_ptr;
    logic [hs5_pkg::QPtrBits-1:0]  r_rd_ptr;
    logic [hs5_pkg::QCntBits-1:0]  r_count;
    logic                          w_pop;

    assign o_valid = (r_count != '0);
    assign o_item  = r_slot[r_rd_ptr];
    assign o_count = r_count;
    assign w_pop   = i_pop && o_valid;

    // Pointers and fill level.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + hs5_pkg::QPtrBits'(1);
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + hs5_pkg::QPtrBits'(1);
            end
            if (i_push && !w_pop) begin
                r_count <= r_count + hs5_pkg::QCntBits'(1);
            end else if (!i_push && w_pop) begin
                r_count <= r_count - hs5_pkg::QCntBits'(1);
            end
        end
    end

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_item;
        end
    end

endmodule

/* src/hs5_back.sv */
// Back part: stencil weighting, truncation, saturation and the output register.
module hs5_back (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [hs5_pkg::CoeffBits-1:0]         i_coeff,
    input  logic                                  i_q_valid,
    input  hs5_pkg::t_item                        i_item,
    output logic                                  o_pop,
    output logic                                  o_out_valid,
    input  logic                                  i_out_ready,
    output logic signed [hs5_pkg::SampleBits-1:0] o_value,
    output logic                                  o_frame_last
);

    localparam int PB = hs5_pkg::ProdBits;
    localparam int TB = hs5_pkg::TotalBits;
    localparam int SB = hs5_pkg::SampleBits;
    localparam int SelBits = PB - hs5_pkg::FracBits;

    logic signed [hs5_pkg::BetaBits-1:0]  w_beta;
    logic signed [hs5_pkg::AlphaBits-1:0] w_alpha;
    logic                                 w_b2_free;
    logic                                 w_b1_adv;

    logic                 r_b1_valid;
    logic signed [PB-1:0] r_p1;
    logic signed [PB-1:0] r_p2;
    logic                 r_b1_last;

    logic signed [SelBits-1:0] w_p1s;
    logic signed [SelBits-1:0] w_p2s;
    logic signed [TB-1:0]      w_total;
    logic [SB-1:0]             w_sat;

    logic          r_out_valid;
    logic [SB-1:0] r_value;
    logic          r_last;

    // Stage handshakes: each stage moves when the one after it has room.
    assign w_b2_free = !r_out_valid || i_out_ready;
    assign w_b1_adv  = !r_b1_valid || w_b2_free;
    assign o_pop     = i_q_valid && w_b1_adv;

    // beta = 1 - 4a in Q2.16, alpha widened to a signed operand.
    assign w_beta  = $signed(hs5_pkg::BetaOne - {1'b0, i_coeff, 2'b00});
    assign w_alpha = $signed({1'b0, i_coeff});

    // Multiply stage.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b1_valid <= 1'b0;
        end else if (w_b1_adv) begin
            r_b1_valid <= i_q_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_p1      <= w_beta * $signed(i_item.centre);
            r_p2      <= w_alpha * $signed(i_item.sum);
            r_b1_last <= i_item.last;
        end
    end

    // Drop the fraction bits (floor), add, and saturate to a sample.
    assign w_p1s   = r_p1[PB-1:hs5_pkg::FracBits];
    assign w_p2s   = r_p2[PB-1:hs5_pkg::FracBits];
    assign w_total = TB'(w_p1s) + TB'(w_p2s);

    always_comb begin
        if ((&w_total[TB-1:SB-1]) || !(|w_total[TB-1:SB-1])) begin
            w_sat = w_total[SB-1:0];
        end else if (w_total[TB-1]) begin
            w_sat = hs5_pkg::SatMinNeg;
        end else begin
            w_sat = hs5_pkg::SatMaxPos;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_b2_free) begin
            r_out_valid <= r_b1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_b2_free && r_b1_valid) begin
            r_value <= w_sat;
            r_last  <= r_b1_last;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_value      = $signed(r_value);
    assign o_frame_last = r_last;

endmodule

/* src/heat_stencil_5point.sv */
// Top level of the five-point heat stencil: configuration registers and part wiring.
//
//   Channel   Direction  Handshake                     Payload
//   input     in         i_in_valid / o_in_ready       i_sample
//   result    out        o_out_valid / i_out_ready     o_value, o_frame_last
//   config    in         i_cfg_we (no wait)            i_cfg_index, i_cfg_data
//
// One sample is taken per cycle while o_in_ready is high; a result passes the second front
// stage, queue, multiply and output registers to o_out_valid. The line stores' three read
// ports and one write port serve one sample each cycle. After reset a clearing pass zeroes
// the MAX_COLS+2 entries (1026 by default) of both line stores; o_in_ready stays low during
// it while configuration writes are taken. A stalled output fills a four-entry queue;
// o_in_ready drops when that queue plus the sample in flight would fill it.
module heat_stencil_5point #(
    parameter int MAX_COLS = 1024
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic signed [hs5_pkg::SampleBits-1:0]   i_sample,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic signed [hs5_pkg::SampleBits-1:0]   o_value,
    output logic                                    o_frame_last,
    input  logic                                    i_cfg_we,
    input  logic [hs5_pkg::CfgIdxBits-1:0]          i_cfg_index,
    input  logic [hs5_pkg::CfgDataBits-1:0]         i_cfg_data
);

    hs5_pkg::t_cfg                  r_cfg;
    logic                           w_restart;
    logic                           w_push;
    hs5_pkg::t_item                 w_push_item;
    logic                           w_q_valid;
    hs5_pkg::t_item                 w_q_item;
    logic [hs5_pkg::QCntBits-1:0]   w_q_count;
    logic                           w_pop;

    // Register write decode; a write to a known register restarts the frame.
    always_comb begin
        w_restart = 1'b0;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                hs5_pkg::CFG_GRID_COLS,
                hs5_pkg::CFG_GRID_ROWS,
                hs5_pkg::CFG_DIFFUSION_COEFF: w_restart = 1'b1;
                default:                      w_restart = 1'b0;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.grid_cols       <= hs5_pkg::CfgBits'(16);
            r_cfg.grid_rows       <= hs5_pkg::CfgBits'(16);
            r_cfg.diffusion_coeff <= hs5_pkg::CoeffBits'(6554);
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                hs5_pkg::CFG_GRID_COLS: begin
                    r_cfg.grid_cols <= i_cfg_data[hs5_pkg::CfgBits-1:0];
                end
                hs5_pkg::CFG_GRID_ROWS: begin
                    r_cfg.grid_rows <= i_cfg_data[hs5_pkg::CfgBits-1:0];
                end
                hs5_pkg::CFG_DIFFUSION_COEFF: begin
                    r_cfg.diffusion_coeff <= i_cfg_data[hs5_pkg::CoeffBits-1:0];
                end
                default: begin
                    r_cfg <= r_cfg;
                end
            endcase
        end
    end

    // Front: counters, line stores and classification.
    hs5_front #(
        .MAX_COLS (MAX_COLS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (r_cfg),
        .i_restart  (w_restart),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sample   (i_sample),
        .i_q_count  (w_q_count),
        .o_push     (w_push),
        .o_item     (w_push_item)
    );

    // Queue between the two parts.
    hs5_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_push_item),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item),
        .o_count (w_q_count)
    );

    // Back: weighting and saturation.
    hs5_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_coeff      (r_cfg.diffusion_coeff),
        .i_q_valid    (w_q_valid),
        .i_item       (w_q_item),
        .o_pop        (w_pop),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_value      (o_value),
        .o_frame_last (o_frame_last)
    );

endmodule

/* src/hs5_checker.sv */
// Port-level checks for the five-point heat stencil, bound to the top level.
module hs5_checker (
    input logic                                  i_clk,
    input logic                                  i_rst_n,
    input logic                                  i_in_ready,
    input logic                                  i_out_valid,
    input logic                                  i_out_ready,
    input logic signed [hs5_pkg::SampleBits-1:0] i_value,
    input logic                                  i_frame_last
);

    // A held result keeps its payload until its transfer.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=>
            i_out_valid && $stable(i_value) && $stable(i_frame_last))
        else $error("result changed while stalled");

    // Reset empties the result path and starts the store clearing pass.
    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid && !i_in_ready)
        else $error("not idle after reset");

    // The first cycle out of reset still belongs to the clearing pass.
    a_clear_after_reset: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_rst_n) |-> !i_in_ready)
        else $error("input taken before line stores were cleared");

endmodule

bind heat_stencil_5point hs5_checker u_hs5_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_ready   (o_in_ready),
    .i_out_valid  (o_out_valid),
    .i_out_ready  (i_out_ready),
    .i_value      (o_value),
    .i_frame_last (o_frame_last)
);
